// File: rtl/acsd_pkg.sv
// Shared types and constants for the acoustic shot split detector.
// No dependencies; imported by the core.
`timescale 1ns / 1ps

package acsd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ARM    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,
    STOP_MAX     = 2'd1,
    STOP_MANUAL  = 2'd2,
    STOP_TIMEOUT = 2'd3
  } stop_reason_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHOT_THRESHOLD   = 3'd0,
    CFG_RECOIL_THRESHOLD = 3'd1,
    CFG_REFRACTORY_MS    = 3'd2,
    CFG_RECOIL_WINDOW_MS = 3'd3,
    CFG_TIMEOUT_MS       = 3'd4,
    CFG_MAX_SHOTS        = 3'd5,
    CFG_RECOIL_MODE      = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] ShotThresholdRst   = 16'd8000;
  localparam logic [14:0] RecoilThresholdRst = 15'd8192;
  localparam logic [15:0] RefractoryRst      = 16'd100;
  localparam logic [15:0] RecoilWindowRst    = 16'd200;
  localparam logic [31:0] TimeoutRst         = 32'd10000;
  localparam logic [6:0]  MaxShotsRst        = 7'd10;

endpackage

// File: rtl/acoustic_shot_split_detector_core.sv
// Shot timer core: acoustic shot detection, recoil confirmation, split timing.
// Depends on acsd_pkg for types, register indexes and reset values.
// Each item passes through an input register and then a result register.
// One item per cycle while out_ready_i does not stall; one pass per item.
// Reset: asynchronous active low; clears run state and restores register defaults.
// Configuration writes are taken every cycle (cfg_ready_o is always high).
`timescale 1ns / 1ps

module acoustic_shot_split_detector_core
  import acsd_pkg::*;
#(
  parameter int unsigned MAX_SHOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [TimeW-1:0]     now_ms_i,
  input  logic [LevelW-1:0]    peak_level_i,
  input  logic signed [15:0]   accel_z_i,
  input  logic                 stop_pressed_i,
  input  logic [TimeW-1:0]     start_time_ms_i,
  input  logic [TimeW-1:0]     listen_time_ms_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 shot_detected_o,
  output logic [TimeW-1:0]     shot_time_ms_o,
  output logic [TimeW-1:0]     split_ms_o,
  output logic [CountW-1:0]    shot_count_o,
  output logic [TimeW-1:0]     elapsed_ms_o,
  output logic                 listening_o,
  output logic                 running_o,
  output logic [1:0]           stop_reason_o,
  output logic [LevelW-1:0]    peak_overall_o
);

  localparam logic [7:0] ShotCap = 8'(MAX_SHOTS);

  // configuration registers
  logic [15:0] shot_thr_q;
  logic [14:0] recoil_thr_q;
  logic [15:0] refractory_q;
  logic [15:0] window_q;
  logic [31:0] timeout_q;
  logic [6:0]  max_shots_q;
  logic        recoil_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shot_thr_q    <= ShotThresholdRst;
      recoil_thr_q  <= RecoilThresholdRst;
      refractory_q  <= RefractoryRst;
      window_q      <= RecoilWindowRst;
      timeout_q     <= TimeoutRst;
      max_shots_q   <= MaxShotsRst;
      recoil_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SHOT_THRESHOLD:   shot_thr_q    <= cfg_data_i[15:0];
        CFG_RECOIL_THRESHOLD: recoil_thr_q  <= cfg_data_i[14:0];
        CFG_REFRACTORY_MS:    refractory_q  <= cfg_data_i[15:0];
        CFG_RECOIL_WINDOW_MS: window_q      <= cfg_data_i[15:0];
        CFG_TIMEOUT_MS:       timeout_q     <= cfg_data_i;
        CFG_MAX_SHOTS:        max_shots_q   <= cfg_data_i[6:0];
        CFG_RECOIL_MODE:      recoil_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic              stage_valid_q;
  logic              op_q;
  logic [TimeW-1:0]  now_q;
  logic [LevelW-1:0] level_q;
  logic [15:0]       az_q;
  logic              stop_btn_q;
  logic [TimeW-1:0]  start_q;
  logic [TimeW-1:0]  listen_at_q;
  logic              advance;
  logic              out_valid_q;

  assign advance    = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q        <= operation_i;
      now_q       <= now_ms_i;
      level_q     <= peak_level_i;
      az_q        <= accel_z_i;
      stop_btn_q  <= stop_pressed_i;
      start_q     <= start_time_ms_i;
      listen_at_q <= listen_time_ms_i;
    end
  end

  // run state
  logic              run_q, run_d;
  logic              listen_q, listen_d;
  logic [CountW-1:0] shots_q, shots_d;
  logic [TimeW-1:0]  run_start_q, run_start_d;
  logic [TimeW-1:0]  listen_from_q, listen_from_d;
  logic [TimeW-1:0]  last_detect_q, last_detect_d;
  logic [TimeW-1:0]  last_shot_q, last_shot_d;
  logic              pending_q, pending_d;
  logic [TimeW-1:0]  peak_at_q, peak_at_d;
  logic [TimeW-1:0]  last_split_q, last_split_d;
  logic [LevelW-1:0] level_max_q, level_max_d;
  stop_reason_e      stop_q, stop_d;

  // result fields of this item
  logic              det;
  logic [TimeW-1:0]  shot_t;
  logic [TimeW-1:0]  split;
  logic [TimeW-1:0]  elapsed;

  always_comb begin
    logic [7:0]       limit;
    logic             gap_ok;
    logic             sound;
    logic [15:0]      mag;
    logic [TimeW-1:0] idle;
    logic [TimeW-1:0] pend_at;
    logic             pend;

    run_d         = run_q;
    listen_d      = listen_q;
    shots_d       = shots_q;
    run_start_d   = run_start_q;
    listen_from_d = listen_from_q;
    last_detect_d = last_detect_q;
    last_shot_d   = last_shot_q;
    pending_d     = pending_q;
    peak_at_d     = peak_at_q;
    last_split_d  = last_split_q;
    level_max_d   = level_max_q;
    stop_d        = stop_q;
    det           = 1'b0;
    shot_t        = '0;
    split         = '0;
    elapsed       = '0;

    limit   = ({1'b0, max_shots_q} < ShotCap) ? {1'b0, max_shots_q} : ShotCap;
    gap_ok  = (shots_q == '0) || ((now_q - last_detect_q) > {16'd0, refractory_q});
    sound   = (level_q > shot_thr_q) && gap_ok && ({1'b0, shots_q} < limit);
    mag     = az_q[15] ? (~az_q + 16'd1) : az_q;
    pend    = pending_q || sound;
    pend_at = pending_q ? peak_at_q : now_q;
    idle    = '0;

    if (op_q == OP_ARM) begin
      run_d         = 1'b1;
      listen_d      = 1'b0;
      shots_d       = '0;
      run_start_d   = start_q;
      listen_from_d = listen_at_q;
      last_detect_d = '0;
      last_shot_d   = '0;
      pending_d     = 1'b0;
      peak_at_d     = '0;
      last_split_d  = '0;
      level_max_d   = '0;
      stop_d        = STOP_NONE;
    end else if (run_q) begin
      if (!listen_q && now_q >= listen_from_q && now_q >= run_start_q) begin
        listen_d = 1'b1;
      end
      if (listen_d) begin
        if (!recoil_mode_q) begin
          if (level_q > level_max_q) begin
            level_max_d = level_q;
          end
          if (sound) begin
            det    = 1'b1;
            shot_t = now_q;
          end
        end else begin
          pending_d = pend;
          peak_at_d = pend_at;
          if (pend) begin
            if (mag > {1'b0, recoil_thr_q}) begin
              det       = 1'b1;
              shot_t    = pend_at;
              pending_d = 1'b0;
              peak_at_d = '0;
            end else if ((now_q - pend_at) > {16'd0, window_q}) begin
              pending_d = 1'b0;
              peak_at_d = '0;
            end
          end
        end

        if (det) begin
          split         = (shots_q == '0) ? (shot_t - run_start_q) : (shot_t - last_shot_q);
          last_detect_d = shot_t;
          last_shot_d   = shot_t;
          last_split_d  = split;
          shots_d       = shots_q + 1'b1;
        end

        // stop order: shot limit, manual stop, timeout
        idle = (shots_d == '0) ? (now_q - run_start_q) : (now_q - last_shot_d);
        if (det && ({1'b0, shots_d} >= limit)) begin
          run_d    = 1'b0;
          listen_d = 1'b0;
          stop_d   = STOP_MAX;
        end else if (stop_btn_q) begin
          run_d    = 1'b0;
          listen_d = 1'b0;
          stop_d   = STOP_MANUAL;
        end else if (idle > timeout_q) begin
          run_d    = 1'b0;
          listen_d = 1'b0;
          stop_d   = STOP_TIMEOUT;
        end

        if (listen_d && now_q > run_start_q) begin
          elapsed = now_q - run_start_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q         <= 1'b0;
      listen_q      <= 1'b0;
      shots_q       <= '0;
      run_start_q   <= '0;
      listen_from_q <= '0;
      last_detect_q <= '0;
      last_shot_q   <= '0;
      pending_q     <= 1'b0;
      peak_at_q     <= '0;
      last_split_q  <= '0;
      level_max_q   <= '0;
      stop_q        <= STOP_NONE;
    end else if (advance) begin
      run_q         <= run_d;
      listen_q      <= listen_d;
      shots_q       <= shots_d;
      run_start_q   <= run_start_d;
      listen_from_q <= listen_from_d;
      last_detect_q <= last_detect_d;
      last_shot_q   <= last_shot_d;
      pending_q     <= pending_d;
      peak_at_q     <= peak_at_d;
      last_split_q  <= last_split_d;
      level_max_q   <= level_max_d;
      stop_q        <= stop_d;
    end
  end

  // result register
  logic              det_q;
  logic [TimeW-1:0]  shot_t_q;
  logic [TimeW-1:0]  split_q;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0]  elapsed_q;
  logic              listening_q;
  logic              running_q;
  logic [1:0]        reason_q;
  logic [LevelW-1:0] peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      det_q       <= det;
      shot_t_q    <= shot_t;
      split_q     <= split;
      count_q     <= shots_d;
      elapsed_q   <= elapsed;
      listening_q <= listen_d;
      running_q   <= run_d;
      reason_q    <= stop_d;
      peak_q      <= level_max_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shot_detected_o = det_q;
  assign shot_time_ms_o  = shot_t_q;
  assign split_ms_o      = split_q;
  assign shot_count_o    = count_q;
  assign elapsed_ms_o    = elapsed_q;
  assign listening_o     = listening_q;
  assign running_o       = running_q;
  assign stop_reason_o   = reason_q;
  assign peak_overall_o  = peak_q;

  // checks
  a_listen_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    listen_q |-> run_q)
    else $error("listening without an active run");

  a_stop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stop_q != STOP_NONE) |-> !run_q)
    else $error("stop reason held while run active");

  a_shot_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && det_q) |-> (count_q != '0))
    else $error("shot reported with zero count");

  a_shot_split_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && det) |=> (last_split_q == split_q && last_shot_q != '0 || shot_t_q == '0
                          || last_shot_q == shot_t_q))
    else $error("shot time not recorded");

  a_result_listen_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && listening_q) |-> running_q)
    else $error("result shows listening while stopped");

endmodule
